// ===== hdl/pdsd_pkg.sv =====
package pdsd_pkg;

    // Sample store geometry
    localparam int SAMPLE_DEPTH = 65536;
    localparam int STORE_ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int VALUE_W      = 48;
    localparam int COUNT_W      = 17;
    localparam int ROM_ADDR_W   = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LATE_GENERATION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_LAST     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PINGPONG_LOOP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LAST       = 3'd4;

    // Result error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_BANK  = 2'd1;
    localparam logic [1:0] ERR_PHASE = 2'd2;

    // Item modes
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_UNWRAP = 1'b1;

    // ROM bank ids and bases
    localparam logic [2:0] BANK_ID_0 = 3'd0;
    localparam logic [2:0] BANK_ID_1 = 3'd1;
    localparam logic [2:0] BANK_ID_2 = 3'd2;
    localparam logic [2:0] BANK_ID_4 = 3'd4;

    localparam logic [ROM_ADDR_W-1:0] BANK_BASE_0 = 24'h000000;
    localparam logic [ROM_ADDR_W-1:0] BANK_BASE_1 = 24'h100000;
    localparam logic [ROM_ADDR_W-1:0] BANK_BASE_2 = 24'h200000;

    localparam logic [4:0] TERM_SHIFT = 5'd14;

    typedef struct packed {
        logic              mode;
        logic signed [7:0] data_byte;
        logic        [7:0] shift_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]    sample_value;
        logic        [ROM_ADDR_W-1:0] data_address;
        logic        [ROM_ADDR_W-1:0] shift_address;
        logic        [COUNT_W-1:0]    sample_index;
        logic        [1:0]            error_code;
        logic                         set_done;
    } t_out_item;

    typedef struct packed {
        logic [22:0] sample_address;
        logic        late_generation;
        logic [15:0] sample_last;
        logic        pingpong_loop;
        logic [15:0] loop_last;
    } t_cfg;

    // Result in flight between the front stage and the output register
    typedef struct packed {
        t_out_item item;
        logic      from_store;
        logic      store_zero;
    } t_stage;

endpackage

// ===== hdl/pcm_rom_dpcm_sample_decoder_core.sv =====
// channel   direction  signals                                   transfer when
// input     in         i_in_valid, o_in_ready, i_in_item          valid && ready
// output    out        o_out_valid, i_out_ready, o_out_item       valid && ready
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,     valid && ready
//                      i_cfg_data
//
// One item per cycle sustained while the output is not stalled; a result becomes valid
// when the output register loads (the front stage register loads at the transfer, then
// the output register; unwrap reads the store in between).
// The sample store is a single-port-write, single-port-read RAM with registered
// read data; the read for an unwrap item is issued when it is taken.
// Reset (i_rst_n low, synchronous) clears config, accumulator, counters and
// valids; the store is not cleared. A stall on the output backs up through the
// two stages to o_in_ready; config is always ready.
module pcm_rom_dpcm_sample_decoder_core
    import pdsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg                    cfg;
    t_stage                  front_stage;
    logic                    wr_en;
    logic [STORE_ADDR_W-1:0] wr_addr;
    logic [VALUE_W-1:0]      wr_data;
    logic                    rd_en;
    logic [STORE_ADDR_W-1:0] rd_addr;
    logic [VALUE_W-1:0]      rd_data;

    logic      r_s1_valid;
    t_stage    r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      s1_move;
    logic      in_ready;
    logic      in_accept;

    assign o_cfg_ready = 1'b1;

    pdsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (in_accept),
        .i_item    (i_in_item),
        .o_stage   (front_stage),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    pdsd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Pipeline flow: store read data holds until the next unwrap transfer,
    // which can only happen as stage 1 empties
    assign s1_move   = !r_out_valid || i_out_ready;
    assign in_ready  = !r_s1_valid || s1_move;
    assign in_accept = i_in_valid && in_ready;

    // Output value: mirrored samples come back negated
    always_comb begin
        n_out = r_s1.item;
        if (r_s1.from_store) begin
            n_out.sample_value = r_s1.store_zero ? '0 : -rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= in_accept;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= front_stage;
        end
        if (s1_move && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/pdsd_ram.sv =====
module pdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/pdsd_cfg.sv =====
module pdsd_cfg
    import pdsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register file write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_ADDRESS:  n_cfg.sample_address  = i_cfg_data;
                CFG_LATE_GENERATION: n_cfg.late_generation = i_cfg_data[0];
                CFG_SAMPLE_LAST:     n_cfg.sample_last     = i_cfg_data[15:0];
                CFG_PINGPONG_LOOP:   n_cfg.pingpong_loop   = i_cfg_data[0];
                CFG_LOOP_LAST:       n_cfg.loop_last       = i_cfg_data[15:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/pdsd_front.sv =====
module pdsd_front
    import pdsd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_accept,
    input  t_in_item                i_item,
    output t_stage                  o_stage,
    output logic                    o_wr_en,
    output logic [STORE_ADDR_W-1:0] o_wr_addr,
    output logic [VALUE_W-1:0]      o_wr_data,
    output logic                    o_rd_en,
    output logic [STORE_ADDR_W-1:0] o_rd_addr
);

    logic [VALUE_W-1:0] r_accumulator;
    logic [COUNT_W-1:0] r_decode_count;
    logic [COUNT_W-1:0] r_mirror_count;
    logic [VALUE_W-1:0] n_accumulator;
    logic [COUNT_W-1:0] n_decode_count;
    logic [COUNT_W-1:0] n_mirror_count;

    logic [ROM_ADDR_W-1:0] bank_base;
    logic                  bank_ok;
    logic [ROM_ADDR_W-1:0] data_addr;
    logic [ROM_ADDR_W-1:0] shift_addr;
    logic [3:0]            nibble;
    logic [31:0]           term;
    logic [VALUE_W-1:0]    acc_sum;
    logic                  dec_phase_err;
    logic                  dec_ok;
    logic [31:0]           dec_count_ext;
    logic                  dec_store_ok;
    logic [COUNT_W-1:0]    sample_last_ext;
    logic [COUNT_W-1:0]    mirror_index;
    logic                  mir_err;
    logic [15:0]           mirror_src;
    logic [31:0]           mirror_src_ext;

    // Bank id to ROM base
    always_comb begin
        bank_ok = 1'b1;
        case (i_cfg.sample_address[22:20])
            BANK_ID_0: bank_base = BANK_BASE_0;
            BANK_ID_1: bank_base = BANK_BASE_1;
            BANK_ID_2: bank_base = i_cfg.late_generation ? BANK_BASE_2 : BANK_BASE_1;
            BANK_ID_4: bank_base = BANK_BASE_2;
            default: begin
                bank_base = BANK_BASE_0;
                bank_ok   = 1'b0;
            end
        endcase
    end

    // ROM addresses and delta term
    assign data_addr  = ({4'd0, i_cfg.sample_address[19:0]} | bank_base)
                        + {7'd0, r_decode_count};
    assign shift_addr = {data_addr[23:20], 5'd0, data_addr[19:5]};
    assign nibble     = data_addr[4] ? i_item.shift_byte[7:4] : i_item.shift_byte[3:0];
    assign term       = {{24{i_item.data_byte[7]}}, i_item.data_byte}
                        << ({1'b0, nibble} + TERM_SHIFT);
    assign acc_sum    = r_accumulator + {{16{term[31]}}, term};

    assign sample_last_ext = {1'b0, i_cfg.sample_last};
    assign dec_phase_err   = r_decode_count > sample_last_ext;
    assign dec_ok          = !dec_phase_err && bank_ok;
    assign dec_count_ext   = {15'd0, r_decode_count};
    assign dec_store_ok    = dec_count_ext < 32'(SAMPLE_DEPTH);

    // Mirror phase: read back the stored samples in reverse order
    assign mirror_index   = sample_last_ext + 17'd1 + r_mirror_count;
    assign mir_err        = !i_cfg.pingpong_loop
                            || (r_decode_count <= sample_last_ext)
                            || (r_mirror_count > {1'b0, i_cfg.loop_last})
                            || (r_mirror_count > sample_last_ext);
    assign mirror_src     = i_cfg.sample_last - r_mirror_count[15:0];
    assign mirror_src_ext = {16'd0, mirror_src};

    // Result of the item presented this cycle
    always_comb begin
        o_stage = '0;
        if (i_item.mode == MODE_DECODE) begin
            o_stage.item.sample_index = r_decode_count;
            if (dec_phase_err) begin
                o_stage.item.error_code = ERR_PHASE;
            end else if (!bank_ok) begin
                o_stage.item.error_code = ERR_BANK;
            end else begin
                o_stage.item.error_code    = ERR_OK;
                o_stage.item.sample_value  = acc_sum;
                o_stage.item.data_address  = data_addr;
                o_stage.item.shift_address = shift_addr;
                o_stage.item.set_done      = (r_decode_count == sample_last_ext)
                                             && !i_cfg.pingpong_loop;
            end
        end else begin
            o_stage.item.sample_index = mirror_index;
            if (mir_err) begin
                o_stage.item.error_code = ERR_PHASE;
            end else begin
                o_stage.item.error_code = ERR_OK;
                o_stage.item.set_done   = r_mirror_count == {1'b0, i_cfg.loop_last};
                o_stage.from_store      = 1'b1;
                o_stage.store_zero      = mirror_src_ext >= 32'(SAMPLE_DEPTH);
            end
        end
    end

    // Store ports
    assign o_wr_en   = i_accept && (i_item.mode == MODE_DECODE) && dec_ok && dec_store_ok;
    assign o_wr_addr = dec_count_ext[STORE_ADDR_W-1:0];
    assign o_wr_data = acc_sum;
    assign o_rd_en   = i_accept && (i_item.mode == MODE_UNWRAP) && !mir_err;
    assign o_rd_addr = mirror_src_ext[STORE_ADDR_W-1:0];

    // State update on an accepted item
    always_comb begin
        n_accumulator  = r_accumulator;
        n_decode_count = r_decode_count;
        n_mirror_count = r_mirror_count;
        if (i_accept) begin
            if (i_item.mode == MODE_DECODE) begin
                if (dec_ok) begin
                    n_accumulator  = acc_sum;
                    n_decode_count = r_decode_count + 17'd1;
                end
            end else if (!mir_err) begin
                n_mirror_count = r_mirror_count + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accumulator  <= '0;
            r_decode_count <= '0;
            r_mirror_count <= '0;
        end else begin
            r_accumulator  <= n_accumulator;
            r_decode_count <= n_decode_count;
            r_mirror_count <= n_mirror_count;
        end
    end

endmodule

// ===== hdl/pdsd_check.sv =====
module pdsd_check
    import pdsd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input t_out_item              o_out_item
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // With the output empty the pipeline always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Error results carry no sample and no addresses
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.error_code != ERR_OK) |->
            (o_out_item.sample_value == '0) && (o_out_item.data_address == '0)
            && (o_out_item.shift_address == '0) && !o_out_item.set_done)
        else $error("error result with payload");

    // Shift byte address follows from the data byte address
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.shift_address ==
            {o_out_item.data_address[23:20], 5'd0, o_out_item.data_address[19:5]})
        else $error("shift address mismatch");

endmodule

bind pcm_rom_dpcm_sample_decoder_core pdsd_check u_pdsd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/tb_pcm_rom_dpcm_sample_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_pcm_rom_dpcm_sample_decoder_core;
    import pdsd_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_OFF     = 80;
    localparam int SETTLE       = 10;
    localparam int REPORT_CAP   = 100;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block ports, all inputs known from time zero
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shared run state
    bit          no_idle     = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned items_sent  = 0;
    int unsigned mismatch_count = 0;

    // Predictor state: live settings, accumulator, counters, copy of stored samples
    t_cfg                active_set     = '0;
    logic [VALUE_W-1:0]  acc_value      = '0;
    logic [COUNT_W-1:0]  decoded_count  = '0;
    logic [COUNT_W-1:0]  mirrored_count = '0;
    logic [VALUE_W-1:0]  sample_copy [int unsigned];

    t_out_item pending_samples [$];

    pcm_rom_dpcm_sample_decoder_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Expected result of one item; advances the predictor state like the block does
    function automatic t_out_item predict_sample(input t_in_item it);
        t_out_item            r;
        logic [ROM_ADDR_W-1:0] base;
        logic [ROM_ADDR_W-1:0] da;
        logic [3:0]           nib;
        logic [31:0]          term;
        logic [COUNT_W-1:0]   src;
        logic [VALUE_W-1:0]   v;
        logic                 bank_ok;
        r       = '0;
        base    = '0;
        bank_ok = 1'b1;
        if (it.mode == MODE_DECODE) begin
            r.sample_index = decoded_count;
            case (active_set.sample_address[22:20])
                BANK_ID_0: base = BANK_BASE_0;
                BANK_ID_1: base = BANK_BASE_1;
                BANK_ID_2: base = active_set.late_generation ? BANK_BASE_2 : BANK_BASE_1;
                BANK_ID_4: base = BANK_BASE_2;
                default:   bank_ok = 1'b0;
            endcase
            if (decoded_count > {1'b0, active_set.sample_last}) begin
                r.error_code = ERR_PHASE;
            end else if (!bank_ok) begin
                r.error_code = ERR_BANK;
            end else begin
                da   = ({4'h0, active_set.sample_address[19:0]} | base)
                       + ROM_ADDR_W'(decoded_count);
                nib  = da[4] ? it.shift_byte[7:4] : it.shift_byte[3:0];
                // sign-extended delta, shifted, kept to 32 bits
                term = {{24{it.data_byte[7]}}, it.data_byte} << (nib + TERM_SHIFT);
                acc_value = acc_value + {{16{term[31]}}, term};
                if (decoded_count < SAMPLE_DEPTH)
                    sample_copy[decoded_count] = acc_value;
                r.sample_value  = acc_value;
                r.data_address  = da;
                r.shift_address = {da[23:20], 5'b00000, da[19:5]};
                r.error_code    = ERR_OK;
                r.set_done      = (decoded_count == {1'b0, active_set.sample_last})
                                  && !active_set.pingpong_loop;
                decoded_count   = decoded_count + 1'b1;
            end
        end else begin
            r.sample_index = {1'b0, active_set.sample_last} + 1'b1 + mirrored_count;
            if (!active_set.pingpong_loop
                    || decoded_count <= {1'b0, active_set.sample_last}
                    || mirrored_count > {1'b0, active_set.loop_last}
                    || mirrored_count > {1'b0, active_set.sample_last}) begin
                r.error_code = ERR_PHASE;
            end else begin
                // mirrored read walks back from the last decoded sample
                src = {1'b0, active_set.sample_last} - mirrored_count;
                v   = sample_copy.exists(src) ? sample_copy[src] : '0;
                r.sample_value = -v;
                r.error_code   = ERR_OK;
                r.set_done     = (mirrored_count == {1'b0, active_set.loop_last});
                mirrored_count = mirrored_count + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_sample(input t_out_item got, input t_out_item want);
        if (got.sample_value !== want.sample_value)
            report_mismatch($sformatf("index %0d sample_value %h, expected %h",
                want.sample_index, got.sample_value, want.sample_value));
        if (got.data_address !== want.data_address)
            report_mismatch($sformatf("index %0d data_address %h, expected %h",
                want.sample_index, got.data_address, want.data_address));
        if (got.shift_address !== want.shift_address)
            report_mismatch($sformatf("index %0d shift_address %h, expected %h",
                want.sample_index, got.shift_address, want.shift_address));
        if (got.sample_index !== want.sample_index)
            report_mismatch($sformatf("sample_index %0d, expected %0d",
                got.sample_index, want.sample_index));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("index %0d error_code %0d, expected %0d",
                want.sample_index, got.error_code, want.error_code));
        if (got.set_done !== want.set_done)
            report_mismatch($sformatf("index %0d set_done %b, expected %b",
                want.sample_index, got.set_done, want.set_done));
    endtask

    // Monitor: register writes, item transfers and result transfers
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SAMPLE_ADDRESS:  active_set.sample_address  = cfg_data[22:0];
                    CFG_LATE_GENERATION: active_set.late_generation = cfg_data[0];
                    CFG_SAMPLE_LAST:     active_set.sample_last     = cfg_data[15:0];
                    CFG_PINGPONG_LOOP:   active_set.pingpong_loop   = cfg_data[0];
                    CFG_LOOP_LAST:       active_set.loop_last       = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = pending_samples.pop_front();
                    check_sample(out_item, want);
                end
            end
            if (in_valid && in_ready)
                pending_samples.insert(pending_samples.size(), predict_sample(in_item));
        end
    end

    // Result sink: random stall per result, plus an optional long hold-off
    initial begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offer one item; valid stays up into the next item when no gap is drawn
    task automatic send_item(input logic mode, input logic [7:0] data, input logic [7:0] shift);
        t_in_item    it;
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.mode       = mode;
        it.data_byte  = data;
        it.shift_byte = shift;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0) @(posedge clk);
    endtask

    // Write all five registers back to back; unused upper bits may get random junk
    task automatic program_set(input t_cfg c, input bit with_unmapped);
        logic [CFG_INDEX_W-1:0] reg_index [5];
        logic [CFG_DATA_W-1:0]  reg_value [5];
        int                     reg_width [5];
        logic [CFG_DATA_W-1:0]  junk;
        reg_index = '{CFG_SAMPLE_ADDRESS, CFG_LATE_GENERATION, CFG_SAMPLE_LAST,
                      CFG_PINGPONG_LOOP, CFG_LOOP_LAST};
        reg_value = '{CFG_DATA_W'(c.sample_address), CFG_DATA_W'(c.late_generation),
                      CFG_DATA_W'(c.sample_last), CFG_DATA_W'(c.pingpong_loop),
                      CFG_DATA_W'(c.loop_last)};
        reg_width = '{23, 1, 16, 1, 16};
        for (int i = 0; i < 5; i++) begin
            junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) << reg_width[i] : '0;
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= reg_value[i] | junk;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        // indexes past the register map must be ignored
        if (with_unmapped) begin
            for (int k = CFG_LOOP_LAST + 1; k < (1 << CFG_INDEX_W); k++) begin
                cfg_valid <= 1'b1;
                cfg_index <= CFG_INDEX_W'(k);
                cfg_data  <= CFG_DATA_W'($urandom);
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Reset settings: one sample set of one sample, then out-of-phase items
    task automatic test_reset_state();
        send_item(MODE_DECODE, 8'h7F, 8'hFF);
        send_item(MODE_DECODE, 8'h80, 8'h00);
        send_item(MODE_UNWRAP, 8'h00, 8'h00);
        wait_drained();
    endtask

    // Every bank id: unknown ids flag, known ids map (both generations for id 2)
    task automatic test_bank_map();
        logic [2:0]  bank_list [5];
        logic        late_list [5];
        logic [19:0] offs_list [5];
        logic [7:0]  data_list [10];
        logic [7:0]  shift_list [10];
        bank_list  = '{BANK_ID_0, BANK_ID_1, BANK_ID_2, BANK_ID_2, BANK_ID_4};
        late_list  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
        offs_list  = '{20'h00010, 20'hFFFFF, 20'h0000E, 20'h7FFEF, 20'hFFFF0};
        data_list  = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h81, 8'h7E};
        shift_list = '{8'hFF, 8'h00, 8'hF0, 8'h0F, 8'hA5, 8'h00, 8'hFF, 8'hF0, 8'h3C, 8'hC3};
        for (int b = 0; b < 8; b++) begin
            if (!(3'(b) inside {BANK_ID_0, BANK_ID_1, BANK_ID_2, BANK_ID_4})) begin
                program_set(t_cfg'{{3'(b), (b == 7) ? 20'hFFFFF : 20'($urandom)},
                                   1'b0, 16'd40, 1'b0, 16'd0}, 1'b0);
                send_item(MODE_DECODE, 8'($urandom), 8'($urandom));
                wait_drained();
            end
        end
        for (int i = 0; i < 5; i++) begin
            program_set(t_cfg'{{bank_list[i], offs_list[i]}, late_list[i],
                               16'd40, 1'b0, 16'd0}, 1'b0);
            send_item(MODE_DECODE, data_list[2*i], shift_list[2*i]);
            send_item(MODE_DECODE, data_list[2*i+1], shift_list[2*i+1]);
            wait_drained();
        end
    endtask

    // Ping-pong: unwrap too early, decode to the end, mirror the loop, overrun it
    task automatic test_pingpong();
        program_set(t_cfg'{{BANK_ID_0, 20'h00100}, 1'b0, 16'(decoded_count + 1),
                           1'b1, 16'd1}, 1'b1);
        send_item(MODE_UNWRAP, 8'h55, 8'hAA);
        send_item(MODE_DECODE, 8'h80, 8'hFF);
        send_item(MODE_DECODE, 8'h7F, 8'hEE);
        send_item(MODE_UNWRAP, 8'h00, 8'h00);
        send_item(MODE_UNWRAP, 8'hFF, 8'hFF);
        send_item(MODE_UNWRAP, 8'h00, 8'h00);
        wait_drained();
    endtask

    // Receiver holds off while the sender streams, so the block backs up
    task automatic test_output_stall();
        program_set(t_cfg'{{BANK_ID_1, 20'($urandom)}, 1'b0, 16'(decoded_count + 29),
                           1'b0, 16'd0}, 1'b0);
        no_idle     = 1'b1;
        hold_cycles = HOLD_OFF;
        repeat (30) send_item(MODE_DECODE, 8'($urandom), 8'($urandom));
        wait_drained();
        no_idle = 1'b0;
    endtask

    // One random sample set: settings, decodes, a mirrored loop when ping-pong is set, some noise
    task automatic run_random_set();
        t_cfg        c;
        logic [2:0]  bank;
        int unsigned n_dec;
        int unsigned n_unw;
        int unsigned kind;
        no_idle = ($urandom_range(0, 3) == 0);
        n_dec   = $urandom_range(1, 24);
        n_unw   = $urandom_range(1, n_dec + 4);
        kind    = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) begin
            do bank = 3'($urandom);
            while (bank inside {BANK_ID_0, BANK_ID_1, BANK_ID_2, BANK_ID_4});
        end else begin
            case ($urandom_range(0, 3))
                0:       bank = BANK_ID_0;
                1:       bank = BANK_ID_1;
                2:       bank = BANK_ID_2;
                default: bank = BANK_ID_4;
            endcase
        end
        c.sample_address  = {bank, ($urandom_range(0, 7) == 0)
                             ? 20'hFFFFF - 20'($urandom_range(0, 40)) : 20'($urandom)};
        c.late_generation = 1'($urandom);
        c.pingpong_loop   = 1'($urandom);
        c.sample_last     = 16'(decoded_count + n_dec - 1);
        c.loop_last       = 16'(mirrored_count + n_unw - 1);
        case (kind)
            0: c.sample_last = 16'hFFFF;
            1: begin
                // shrink the set below what is decoded and mirror past its start
                c.pingpong_loop = 1'b1;
                c.sample_last   = 16'(mirrored_count + $urandom_range(0, 8));
                if (c.sample_last >= decoded_count)
                    c.sample_last = 16'(decoded_count - 1);
                c.loop_last = 16'hFFFF;
                n_dec = 0;
                n_unw = 12;
            end
            2: begin
                c.sample_last = '0;
                c.loop_last   = '0;
            end
            3: c.loop_last = 16'hFFFF;
            default: ;
        endcase
        program_set(c, $urandom_range(0, 7) == 0);
        repeat (n_dec) begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'($urandom), 8'($urandom), 8'($urandom));
            send_item(MODE_DECODE, 8'($urandom), 8'($urandom));
        end
        if (c.pingpong_loop) begin
            repeat (n_unw + $urandom_range(0, 2))
                send_item(MODE_UNWRAP, 8'($urandom), 8'($urandom));
        end else begin
            repeat ($urandom_range(0, 2))
                send_item(1'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_random_sets();
        int unsigned first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
            run_random_set();
        no_idle = 1'b0;
    endtask

    // Sequence of tests
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_bank_map();
        test_pingpong();
        test_output_stall();
        test_random_sets();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pdsd_pkg.sv
hdl/pdsd_ram.sv
hdl/pdsd_cfg.sv
hdl/pdsd_front.sv
hdl/pcm_rom_dpcm_sample_decoder_core.sv
hdl/pdsd_check.sv
tb/sv/tb_pcm_rom_dpcm_sample_decoder_core.sv
